@@ src/adrk4_pkg.sv @@
// Shared types, codes and defaults of the advection-diffusion RK4 grid engine.
package adrk4_pkg;

	// default sizes
	localparam int MAX_GRID_WIDTH_DEF  = 64;
	localparam int MAX_GRID_HEIGHT_DEF = 64;
	localparam int VALUE_BITS_DEF      = 32;
	localparam int GRID_DIM_MIN        = 3;

	// item kinds
	typedef enum logic [1:0] {
		KIND_WRITE = 2'd0,
		KIND_READ  = 2'd1,
		KIND_STEP  = 2'd2
	} kind_t;

	// configuration register indexes
	typedef enum logic [1:0] {
		CFG_GRID_WIDTH  = 2'd0,
		CFG_GRID_HEIGHT = 2'd1,
		CFG_INV_SPACING = 2'd2,
		CFG_DIFFUSIVITY = 2'd3
	} cfg_index_t;

	// input transaction payload
	typedef struct packed {
		logic        [1:0]  kind;
		logic        [11:0] cell_address;
		logic signed [31:0] temperature_in;
		logic signed [31:0] wind_x_in;
		logic signed [31:0] wind_y_in;
		logic        [30:0] time_step;
	} item_in_t;

	// output transaction payload
	typedef struct packed {
		logic signed [31:0] temperature_out;
		logic               step_done;
	} item_out_t;

	// command to the shared scaling unit
	typedef struct packed {
		logic start;
		logic half;
		logic div6;
	} scale_ctl_t;

	// scaling unit sequencer
	typedef enum logic [2:0] {
		SC_IDLE,
		SC_MUL,
		SC_SAT,
		SC_DIV,
		SC_FIN,
		SC_DONE
	} scale_state_t;

	// grid sequencer
	typedef enum logic [3:0] {
		SEQ_IDLE,
		SEQ_READ,
		SEQ_DFETCH,
		SEQ_DMSTART,
		SEQ_DMWAIT,
		SEQ_DWRITE,
		SEQ_UISSUE,
		SEQ_UCAP,
		SEQ_UMSTART,
		SEQ_UMWAIT
	} seq_state_t;

endpackage

@@ src/adrk4_scale.sv @@
// Shared bit-serial unit: sat(trunc(x*y / 2^16 or 2^17 / 1 or 6)) in signed fixed point.
module adrk4_scale import adrk4_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF,
	localparam int XW = VALUE_BITS + 4,
	localparam int YW = ((VALUE_BITS > 31) ? VALUE_BITS : 31) + 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  scale_ctl_t                   ctl,
	input  logic signed [XW-1:0]         x,
	input  logic signed [YW-1:0]         y,
	output logic                         done,
	output logic signed [VALUE_BITS-1:0] res
);

	localparam int VB   = VALUE_BITS;
	localparam int PW   = XW + YW;
	localparam int CW   = $clog2(YW);
	// divide by six as a halving and a reciprocal multiply by ceil(2^RK / 3), RK odd
	localparam int RK   = ((VB % 2) == 0) ? VB + 1 : VB + 2;
	localparam logic [63:0]   RK_POW  = 64'd1 << RK;
	localparam logic [XW-1:0] RECIP   = XW'((RK_POW + 64'd1) / 64'd3);
	localparam logic [VB-1:0] VMAX    = {1'b0, {(VB-1){1'b1}}};
	localparam logic [PW-1:0] DIV_LIM = {{(PW-VB-2){1'b0}}, 2'b11, {VB{1'b0}}};

	scale_state_t   st_q, st_d;
	logic           neg_q, half_q, div6_q;
	logic [XW-1:0]  xm_q;
	logic [PW-1:0]  p_q;
	logic [CW-1:0]  cnt_q;
	logic [VB-1:0]  mag_q;

	logic [VB-1:0]  lim;
	logic [XW:0]    psum;
	logic [PW-1:0]  qs;
	logic [PW-1:0]  qd;

	// magnitude limit: one more on the negative side
	assign lim = VMAX + {{(VB-1){1'b0}}, neg_q};

	// multiply step, shift and reciprocal quotient
	assign psum = {1'b0, p_q[PW-1:YW]} + {1'b0, (p_q[0] ? xm_q : {XW{1'b0}})};
	assign qs   = half_q ? (p_q >> 17) : (p_q >> 16);
	assign qd   = p_q >> RK;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= SC_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			SC_IDLE: if (ctl.start) st_d = SC_MUL;
			SC_MUL:  if (cnt_q == CW'(YW - 1)) st_d = SC_SAT;
			SC_SAT: begin
				if (div6_q && qs < DIV_LIM) st_d = SC_DIV;
				else st_d = SC_DONE;
			end
			SC_DIV:  if (cnt_q == CW'(YW - 1)) st_d = SC_FIN;
			SC_FIN:  st_d = SC_DONE;
			SC_DONE: st_d = SC_IDLE;
			default: st_d = SC_IDLE;
		endcase
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (st_q)
			SC_IDLE: begin
				neg_q  <= x[XW-1] ^ y[YW-1];
				half_q <= ctl.half;
				div6_q <= ctl.div6;
				xm_q   <= x[XW-1] ? XW'(-x) : XW'(x);
				p_q    <= {{XW{1'b0}}, (y[YW-1] ? YW'(-y) : YW'(y))};
				cnt_q  <= '0;
			end
			SC_MUL, SC_DIV: begin
				p_q   <= {psum, p_q[YW-1:1]};
				cnt_q <= cnt_q + CW'(1);
			end
			SC_SAT: begin
				cnt_q <= '0;
				if (div6_q) begin
					// quotient of at least 2^(VB-1) saturates; else multiply the half by 1/3
					mag_q <= lim;
					xm_q  <= RECIP;
					p_q   <= {{XW{1'b0}}, YW'(qs[VB+1:1])};
				end else if (qs > {{(PW-VB){1'b0}}, lim}) begin
					mag_q <= lim;
				end else begin
					mag_q <= qs[VB-1:0];
				end
			end
			SC_FIN: begin
				mag_q <= (qd > {{(PW-VB){1'b0}}, lim}) ? lim : qd[VB-1:0];
			end
			default: ;
		endcase
	end

	assign done = (st_q == SC_DONE);
	assign res  = neg_q ? -$signed(mag_q) : $signed(mag_q);

endmodule

@@ src/advection_diffusion_rk4_grid_step_unit.sv @@
// Top level: grid memories, cell sequencer and RK4 stage control around the scaling unit.
//
//  channel  direction  handshake             payload
//  in       input      in_valid / in_ready   item_in_t   (write, read, step)
//  out      output     out_valid / out_ready item_out_t  (read value or step done)
//  cfg      input      cfg_valid / cfg_ready cfg_index, cfg_data (always ready)
//
// A cell write goes to memory as the item is taken; a read passes a registered memory read
// and then the output register. A step runs four slope sweeps and four update sweeps over
// N = cols*rows cells; every product goes through the bit-serial multiplier of the shared
// scaling unit (YW = 33 for 32-bit values), and the last update sweep adds a serial divide
// by six per cell.
// Input is taken only in idle with the output register empty; out_ready stalls only
// the output. Reset clears control and configuration; grid memories are not cleared.
module advection_diffusion_rk4_grid_step_unit import adrk4_pkg::*; #(
	parameter int MAX_GRID_WIDTH  = MAX_GRID_WIDTH_DEF,
	parameter int MAX_GRID_HEIGHT = MAX_GRID_HEIGHT_DEF,
	parameter int VALUE_BITS      = VALUE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  item_in_t    in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output item_out_t   out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int DEPTH = MAX_GRID_WIDTH * MAX_GRID_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int VB    = VALUE_BITS;
	localparam int SW    = VB + 8;
	localparam int XW    = VB + 4;
	localparam int YW    = ((VB > 31) ? VB : 31) + 1;
	localparam int LW    = (SW > 40) ? SW : 40;
	localparam logic signed [LW-1:0] V_MAX = {{(LW-VB+1){1'b0}}, {(VB-1){1'b1}}};
	localparam logic signed [LW-1:0] V_MIN = {{(LW-VB+1){1'b1}}, {(VB-1){1'b0}}};
	localparam logic signed [LW-1:0] O_MAX = {{(LW-31){1'b0}}, {31{1'b1}}};
	localparam logic signed [LW-1:0] O_MIN = {{(LW-31){1'b1}}, {31{1'b0}}};
	localparam logic [2:0] FC_LAST    = 3'd5;
	localparam logic [2:0] M_LAST     = 3'd6;
	localparam logic [1:0] STAGE_LAST = 2'd3;

	// sign extensions and saturation
	function automatic logic signed [XW-1:0] xext(input logic signed [VB-1:0] v);
		return {{4{v[VB-1]}}, v};
	endfunction

	function automatic logic signed [YW-1:0] yext(input logic signed [VB-1:0] v);
		return {{(YW-VB){v[VB-1]}}, v};
	endfunction

	function automatic logic signed [LW-1:0] lext(input logic signed [VB-1:0] v);
		return {{(LW-VB){v[VB-1]}}, v};
	endfunction

	function automatic logic signed [SW-1:0] sext(input logic signed [VB-1:0] v);
		return {{8{v[VB-1]}}, v};
	endfunction

	function automatic logic signed [VB-1:0] sat_v(input logic signed [LW-1:0] v);
		logic signed [VB-1:0] r;
		if (v > V_MAX) r = V_MAX[VB-1:0];
		else if (v < V_MIN) r = V_MIN[VB-1:0];
		else r = v[VB-1:0];
		return r;
	endfunction

	// grid memories
	logic signed [VB-1:0] t_mem  [DEPTH];
	logic signed [VB-1:0] wx_mem [DEPTH];
	logic signed [VB-1:0] wy_mem [DEPTH];
	logic signed [VB-1:0] a_mem  [DEPTH];
	logic signed [VB-1:0] b_mem  [DEPTH];
	logic signed [SW-1:0] s_mem  [DEPTH];

	// control state
	seq_state_t   state_q, state_d;
	logic         out_valid_q;
	logic [6:0]   width_q, height_q;
	logic [30:0]  inv_q, kap_q;
	logic [AW-1:0] i_q;
	logic [6:0]   c_q, r_q;
	logic [2:0]   fc_q, m_q;
	logic [1:0]   stage_q;

	// payload registers
	item_out_t            out_q;
	logic                 rd_ok_q;
	logic [30:0]          dt_q;
	logic signed [VB-1:0] ctr_q, lft_q, rgt_q, up_q, dn_q, wx_q, wy_q;
	logic signed [VB-1:0] gx_q, gy_q, lap_q, kl_q, ax_q, ay_q;
	logic signed [VB-1:0] ua_q, ut_q;
	logic signed [SW-1:0] us_q;

	// memory ports
	logic signed [VB-1:0] t_rdata, wx_rdata, wy_rdata, a_rdata, b_rdata;
	logic signed [SW-1:0] s_rdata;
	logic                 t_we, wind_we, a_we, b_we, s_we;
	logic [AW-1:0]        t_waddr, t_raddr, fetch_addr;
	logic signed [VB-1:0] t_wdata;

	// misc
	logic [6:0]           cols, rows;
	logic [13:0]          n_cells;
	logic                 accept, addr_ok, cell_last;
	logic [AW-1:0]        addr_idx, cols_ext;
	logic                 c_first, c_last, r_first, r_last, edge_r, edge_c;
	logic signed [VB-1:0] src;
	logic signed [XW-1:0] gx_diff, gy_diff, lap_sum;
	logic signed [SW-1:0] s_new;
	logic signed [VB-1:0] a_new, upd_val;
	logic signed [LW-1:0] rd_ext;
	logic signed [31:0]   rd_val;
	scale_ctl_t           ctl;
	logic signed [XW-1:0] op_x;
	logic signed [YW-1:0] op_y;
	logic                 op_half, op_div6;
	logic                 sc_done;
	logic signed [VB-1:0] sc_res;

	// grid size in use
	always_comb begin
		if (width_q < 7'(GRID_DIM_MIN)) cols = 7'(GRID_DIM_MIN);
		else if (int'(width_q) > MAX_GRID_WIDTH) cols = 7'(MAX_GRID_WIDTH);
		else cols = width_q;
		if (height_q < 7'(GRID_DIM_MIN)) rows = 7'(GRID_DIM_MIN);
		else if (int'(height_q) > MAX_GRID_HEIGHT) rows = 7'(MAX_GRID_HEIGHT);
		else rows = height_q;
	end

	assign n_cells  = 14'(cols) * 14'(rows);
	assign addr_ok  = {2'b00, in_data.cell_address} < n_cells;
	assign addr_idx = AW'({{AW{1'b0}}, in_data.cell_address});
	assign cols_ext = AW'({{AW{1'b0}}, cols});
	assign accept   = in_valid && in_ready;

	// cell position
	assign c_first   = (c_q == 7'd0);
	assign c_last    = (c_q == cols - 7'd1);
	assign r_first   = (r_q == 7'd0);
	assign r_last    = (r_q == rows - 7'd1);
	assign edge_r    = r_first || r_last;
	assign edge_c    = c_first || c_last;
	assign cell_last = c_last && r_last;

	// stencil fetch order: center, left, right, up, down
	always_comb begin
		unique case (fc_q)
			3'd0:    fetch_addr = i_q;
			3'd1:    fetch_addr = i_q - AW'(1);
			3'd2:    fetch_addr = i_q + AW'(1);
			3'd3:    fetch_addr = i_q - cols_ext;
			3'd4:    fetch_addr = i_q + cols_ext;
			default: fetch_addr = i_q;
		endcase
	end

	assign src = (stage_q == 2'd0) ? t_rdata : b_rdata;

	// gradient and Laplacian stencils
	always_comb begin
		if (c_first) gx_diff = xext(rgt_q) - xext(ctr_q);
		else if (c_last) gx_diff = xext(ctr_q) - xext(lft_q);
		else if (!edge_r) gx_diff = xext(rgt_q) - xext(lft_q);
		else gx_diff = '0;

		if (r_first) gy_diff = xext(dn_q) - xext(ctr_q);
		else if (r_last) gy_diff = xext(ctr_q) - xext(up_q);
		else if (!edge_c) gy_diff = xext(dn_q) - xext(up_q);
		else gy_diff = '0;

		if (edge_r && edge_c) lap_sum = '0;
		else if (r_first) lap_sum = (xext(dn_q) - xext(ctr_q)) <<< 1;
		else if (r_last) lap_sum = (xext(up_q) - xext(ctr_q)) <<< 1;
		else if (c_first) lap_sum = (xext(rgt_q) - xext(ctr_q)) <<< 1;
		else if (c_last) lap_sum = (xext(lft_q) - xext(ctr_q)) <<< 1;
		else lap_sum = xext(lft_q) + xext(rgt_q) + xext(up_q) + xext(dn_q)
			- (xext(ctr_q) <<< 2);
	end

	// slope and stage results
	assign a_new = sat_v(lext(kl_q) - lext(ax_q) - lext(ay_q));
	assign upd_val = sat_v(lext(ut_q) + lext(sc_res));

	always_comb begin
		unique case (stage_q)
			2'd0:    s_new = sext(ua_q);
			2'd3:    s_new = us_q + sext(ua_q);
			default: s_new = us_q + (sext(ua_q) <<< 1);
		endcase
	end

	// operands of the scaling unit
	always_comb begin
		op_x    = '0;
		op_y    = '0;
		op_half = 1'b0;
		op_div6 = 1'b0;
		if (state_q == SEQ_UMSTART) begin
			op_x    = (stage_q == STAGE_LAST) ? s_new[XW-1:0] : xext(ua_q);
			op_y    = {{(YW-31){1'b0}}, dt_q};
			op_half = (stage_q < 2'd2);
			op_div6 = (stage_q == STAGE_LAST);
		end else begin
			unique case (m_q)
				3'd0: begin
					op_x    = gx_diff;
					op_y    = {{(YW-31){1'b0}}, inv_q};
					op_half = !edge_c && !edge_r;
				end
				3'd1: begin
					op_x    = gy_diff;
					op_y    = {{(YW-31){1'b0}}, inv_q};
					op_half = !edge_r && !edge_c;
				end
				3'd2: begin
					op_x = lap_sum;
					op_y = {{(YW-31){1'b0}}, inv_q};
				end
				3'd3: begin
					op_x = xext(lap_q);
					op_y = {{(YW-31){1'b0}}, inv_q};
				end
				3'd4: begin
					op_x = xext(lap_q);
					op_y = {{(YW-31){1'b0}}, kap_q};
				end
				3'd5: begin
					op_x = xext(gx_q);
					op_y = yext(wx_q);
				end
				3'd6: begin
					op_x = xext(gy_q);
					op_y = yext(wy_q);
				end
				default: ;
			endcase
		end
	end

	adrk4_scale #(
		.VALUE_BITS(VALUE_BITS)
	) u_scale (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (ctl),
		.x     (op_x),
		.y     (op_y),
		.done  (sc_done),
		.res   (sc_res)
	);

	// sequencer next state and strobes
	always_comb begin
		state_d = state_q;
		t_we    = 1'b0;
		wind_we = 1'b0;
		a_we    = 1'b0;
		b_we    = 1'b0;
		s_we    = 1'b0;
		ctl     = '{start: 1'b0, half: op_half, div6: op_div6};
		unique case (state_q)
			SEQ_IDLE: begin
				if (accept) begin
					unique case (in_data.kind)
						KIND_WRITE: begin
							t_we    = addr_ok;
							wind_we = addr_ok;
						end
						KIND_READ: state_d = SEQ_READ;
						KIND_STEP: state_d = SEQ_DFETCH;
						default: ;
					endcase
				end
			end
			SEQ_READ: state_d = SEQ_IDLE;
			SEQ_DFETCH: if (fc_q == FC_LAST) state_d = SEQ_DMSTART;
			SEQ_DMSTART: begin
				ctl.start = 1'b1;
				state_d   = SEQ_DMWAIT;
			end
			SEQ_DMWAIT: begin
				if (sc_done) state_d = (m_q == M_LAST) ? SEQ_DWRITE : SEQ_DMSTART;
			end
			SEQ_DWRITE: begin
				a_we    = 1'b1;
				state_d = cell_last ? SEQ_UISSUE : SEQ_DFETCH;
			end
			SEQ_UISSUE: state_d = SEQ_UCAP;
			SEQ_UCAP:   state_d = SEQ_UMSTART;
			SEQ_UMSTART: begin
				ctl.start = 1'b1;
				state_d   = SEQ_UMWAIT;
			end
			SEQ_UMWAIT: begin
				if (sc_done) begin
					s_we = 1'b1;
					if (stage_q == STAGE_LAST) t_we = 1'b1;
					else b_we = 1'b1;
					if (!cell_last) state_d = SEQ_UISSUE;
					else if (stage_q == STAGE_LAST) state_d = SEQ_IDLE;
					else state_d = SEQ_DFETCH;
				end
			end
			default: state_d = SEQ_IDLE;
		endcase
	end

	// memory address and data selection
	assign t_waddr = (state_q == SEQ_IDLE) ? addr_idx : i_q;
	assign t_wdata = (state_q == SEQ_IDLE)
		? sat_v({{(LW-32){in_data.temperature_in[31]}}, in_data.temperature_in}) : upd_val;

	always_comb begin
		unique case (state_q)
			SEQ_IDLE:   t_raddr = addr_idx;
			SEQ_DFETCH: t_raddr = fetch_addr;
			default:    t_raddr = i_q;
		endcase
	end

	// grid memories, one write and one registered read each
	always_ff @(posedge clk) begin
		if (t_we) t_mem[t_waddr] <= t_wdata;
		t_rdata <= t_mem[t_raddr];
	end

	always_ff @(posedge clk) begin
		if (wind_we) begin
			wx_mem[addr_idx] <= sat_v({{(LW-32){in_data.wind_x_in[31]}}, in_data.wind_x_in});
			wy_mem[addr_idx] <= sat_v({{(LW-32){in_data.wind_y_in[31]}}, in_data.wind_y_in});
		end
		wx_rdata <= wx_mem[i_q];
		wy_rdata <= wy_mem[i_q];
	end

	always_ff @(posedge clk) begin
		if (a_we) a_mem[i_q] <= a_new;
		a_rdata <= a_mem[i_q];
	end

	always_ff @(posedge clk) begin
		if (b_we) b_mem[i_q] <= upd_val;
		b_rdata <= b_mem[fetch_addr];
	end

	always_ff @(posedge clk) begin
		if (s_we) s_mem[i_q] <= s_new;
		s_rdata <= s_mem[i_q];
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SEQ_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 7'd64;
			height_q <= 7'd64;
			inv_q    <= 31'd65536;
			kap_q    <= 31'd0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_GRID_WIDTH:  width_q  <= cfg_data[6:0];
				CFG_GRID_HEIGHT: height_q <= cfg_data[6:0];
				CFG_INV_SPACING: inv_q    <= cfg_data[30:0];
				CFG_DIFFUSIVITY: kap_q    <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	// cell counters and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			i_q         <= '0;
			c_q         <= '0;
			r_q         <= '0;
			fc_q        <= '0;
			m_q         <= '0;
			stage_q     <= '0;
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				SEQ_IDLE: begin
					i_q     <= '0;
					c_q     <= '0;
					r_q     <= '0;
					fc_q    <= '0;
					stage_q <= '0;
				end
				SEQ_READ: out_valid_q <= 1'b1;
				SEQ_DFETCH: begin
					fc_q <= (fc_q == FC_LAST) ? 3'd0 : fc_q + 3'd1;
					m_q  <= '0;
				end
				SEQ_DMWAIT: if (sc_done) m_q <= m_q + 3'd1;
				SEQ_DWRITE, SEQ_UMWAIT: begin
					if (state_q == SEQ_DWRITE || sc_done) begin
						if (cell_last) begin
							i_q <= '0;
							c_q <= '0;
							r_q <= '0;
							if (state_q == SEQ_UMWAIT) begin
								if (stage_q == STAGE_LAST) out_valid_q <= 1'b1;
								stage_q <= stage_q + 2'd1;
							end
						end else begin
							i_q <= i_q + AW'(1);
							if (c_last) begin
								c_q <= '0;
								r_q <= r_q + 7'd1;
							end else begin
								c_q <= c_q + 7'd1;
							end
						end
					end
				end
				default: ;
			endcase
		end
	end

	// read result saturates to 32 bits
	assign rd_ext = lext(t_rdata);
	always_comb begin
		if (rd_ext > O_MAX) rd_val = 32'sh7fffffff;
		else if (rd_ext < O_MIN) rd_val = 32'sh80000000;
		else rd_val = rd_ext[31:0];
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == SEQ_IDLE && accept) begin
			rd_ok_q <= addr_ok;
			dt_q    <= in_data.time_step;
		end
		if (state_q == SEQ_READ) begin
			out_q.temperature_out <= rd_ok_q ? rd_val : 32'sd0;
			out_q.step_done       <= 1'b0;
		end
		if (state_q == SEQ_UMWAIT && sc_done && cell_last && stage_q == STAGE_LAST) begin
			out_q.temperature_out <= 32'sd0;
			out_q.step_done       <= 1'b1;
		end
		// stencil capture, from the registered read of the previous fetch address
		if (state_q == SEQ_DFETCH) begin
			unique case (fc_q)
				3'd1: begin
					ctr_q <= src;
					wx_q  <= wx_rdata;
					wy_q  <= wy_rdata;
				end
				3'd2: lft_q <= c_first ? '0 : src;
				3'd3: rgt_q <= c_last ? '0 : src;
				3'd4: up_q  <= r_first ? '0 : src;
				3'd5: dn_q  <= r_last ? '0 : src;
				default: ;
			endcase
		end
		// scaled products of the slope
		if (state_q == SEQ_DMWAIT && sc_done) begin
			unique case (m_q)
				3'd0:       gx_q  <= sc_res;
				3'd1:       gy_q  <= sc_res;
				3'd2, 3'd3: lap_q <= sc_res;
				3'd4:       kl_q  <= sc_res;
				3'd5:       ax_q  <= sc_res;
				3'd6:       ay_q  <= sc_res;
				default: ;
			endcase
		end
		if (state_q == SEQ_UCAP) begin
			ua_q <= a_rdata;
			ut_q <= t_rdata;
			us_q <= s_rdata;
		end
	end

	assign in_ready  = (state_q == SEQ_IDLE) && !out_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign cfg_ready = 1'b1;

endmodule
